### rtl/core/wrhc_pkg.sv
package wrhc_pkg;

    // default table size
    localparam int NUM_BINS_DEF = 64;

    // field widths
    localparam int OP_W       = 2;
    localparam int STEP_W     = 32;
    localparam int BASE_W     = 31;
    localparam int COST_W     = 16;
    localparam int QBIN_W     = 8;
    localparam int BIN_W      = 6;
    localparam int WEIGHT_W   = 48;
    localparam int LIM_W      = BIN_W + 1;
    localparam int CFG_IDX_W  = 1;
    localparam int CFG_DATA_W = 31;

    // command queue between front and back
    localparam int QUEUE_DEPTH = 4;

    localparam logic [BASE_W-1:0]   BASE_STEP_RST = 31'd16777216;
    localparam logic [BIN_W-1:0]    TOP_BIN_RST   = 6'd63;
    localparam logic [WEIGHT_W-1:0] WEIGHT_MAX    = '1;

    typedef enum logic [OP_W-1:0] {
        OP_ADD   = 2'd0,
        OP_QUERY = 2'd1,
        OP_CLEAR = 2'd2
    } op_t;

    typedef enum logic [CFG_IDX_W-1:0] {
        REG_BASE_STEP = 1'b0,
        REG_TOP_BIN   = 1'b1
    } reg_idx_t;

    // idx: bin for add, bin limit for query
    typedef struct packed {
        op_t               op;
        logic [LIM_W-1:0]  idx;
        logic [COST_W-1:0] cost;
    } cmd_t;

endpackage

### rtl/core/wrhc_if.sv
interface wrhc_item_if;
    logic                                valid;
    logic                                ready;
    logic [wrhc_pkg::OP_W-1:0]           operation;
    logic signed [wrhc_pkg::STEP_W-1:0]  cell_step;
    logic [wrhc_pkg::COST_W-1:0]         cell_cost;
    logic [wrhc_pkg::QBIN_W-1:0]         query_bin;

    modport source (output valid, operation, cell_step, cell_cost, query_bin, input ready);
    modport sink   (input valid, operation, cell_step, cell_cost, query_bin, output ready);
endinterface

interface wrhc_result_if;
    logic                            valid;
    logic                            ready;
    logic [wrhc_pkg::BIN_W-1:0]      bin_index;
    logic [wrhc_pkg::WEIGHT_W-1:0]   weight;

    modport source (output valid, bin_index, weight, input ready);
    modport sink   (input valid, bin_index, weight, output ready);
endinterface

interface wrhc_cfg_if;
    logic                              valid;
    logic                              ready;
    logic [wrhc_pkg::CFG_IDX_W-1:0]    index;
    logic [wrhc_pkg::CFG_DATA_W-1:0]   data;

    modport source (output valid, index, data, input ready);
    modport sink   (input valid, index, data, output ready);
endinterface

### rtl/core/wrhc_front.sv
module wrhc_front #(
    parameter int NUM_BINS = wrhc_pkg::NUM_BINS_DEF
) (
    input  logic                               clk,
    input  logic                               rst_n,
    input  logic                               valid,
    output logic                               ready,
    input  logic [wrhc_pkg::OP_W-1:0]          operation,
    input  logic signed [wrhc_pkg::STEP_W-1:0] cell_step,
    input  logic [wrhc_pkg::COST_W-1:0]        cell_cost,
    input  logic [wrhc_pkg::QBIN_W-1:0]        query_bin,
    input  logic [wrhc_pkg::BASE_W-1:0]        base_step,
    input  logic [wrhc_pkg::BIN_W-1:0]         top_bin,
    output logic                               push_valid,
    output wrhc_pkg::cmd_t                     push_cmd,
    input  logic                               push_ready
);

    localparam int BIN_W  = wrhc_pkg::BIN_W;
    localparam int BASE_W = wrhc_pkg::BASE_W;
    localparam int LIM_W  = wrhc_pkg::LIM_W;
    localparam int QBIN_W = wrhc_pkg::QBIN_W;
    localparam int STEP_W = wrhc_pkg::STEP_W;
    localparam int SH_W   = BASE_W + BIN_W;
    localparam int K_W    = $clog2(BIN_W);
    localparam int BIN_MAX = (1 << BIN_W) - 1;
    localparam int TOP_CAP = (NUM_BINS - 1 < BIN_MAX) ? NUM_BINS - 1 : BIN_MAX;
    localparam logic [BIN_W-1:0] TOP_CAP_B = BIN_W'(TOP_CAP);
    localparam logic [K_W-1:0]   K_START   = K_W'(BIN_W - 1);

    typedef enum logic [2:0] {
        F_IDLE = 3'b001,
        F_DIV  = 3'b010,
        F_PUSH = 3'b100
    } fstate_t;

    fstate_t            state_reg, state_next;
    wrhc_pkg::cmd_t     cmd_reg, cmd_next;
    logic [BASE_W-1:0]  rem_reg, rem_next;
    logic [BASE_W-1:0]  div_reg, div_next;
    logic [BIN_W-1:0]   quot_reg, quot_next;
    logic [K_W-1:0]     k_reg, k_next;

    logic [BIN_W-1:0]   eff_top;
    logic [LIM_W-1:0]   top_lim;
    logic [LIM_W-1:0]   qry_lim;
    logic [BASE_W-1:0]  div_in;
    logic               over_range;
    logic [SH_W-1:0]    shifted;
    logic [SH_W-1:0]    rem_ext;
    logic               ge;
    logic [BIN_W-1:0]   q_bit;
    logic [BIN_W-1:0]   q_full;
    logic [BIN_W-1:0]   q_clamp;

    always_comb
    begin
        eff_top = (top_bin > TOP_CAP_B) ? TOP_CAP_B : top_bin;
        top_lim = LIM_W'(eff_top) + LIM_W'(1);
        qry_lim = (query_bin < QBIN_W'(top_lim)) ? LIM_W'(query_bin) : top_lim;
        div_in  = (base_step == '0) ? BASE_W'(1) : base_step;
        // quotient >= 2^BIN_W exactly when step / 2^BIN_W >= divisor
        over_range = BASE_W'(cell_step[STEP_W-2:BIN_W]) >= div_in;
        // one restoring step per cycle, quotient msb first
        shifted = SH_W'(div_reg) << k_reg;
        rem_ext = SH_W'(rem_reg);
        ge      = rem_ext >= shifted;
        q_bit   = BIN_W'(ge) << k_reg;
        q_full  = quot_reg | q_bit;
        q_clamp = (q_full >= eff_top) ? eff_top : q_full;
    end

    always_comb
    begin
        state_next = state_reg;
        cmd_next   = cmd_reg;
        rem_next   = rem_reg;
        div_next   = div_reg;
        quot_next  = quot_reg;
        k_next     = k_reg;
        case (state_reg)
            F_IDLE:
            begin
                if (valid)
                begin
                    cmd_next.cost = cell_cost;
                    cmd_next.idx  = '0;
                    case (wrhc_pkg::op_t'(operation))
                        wrhc_pkg::OP_ADD:
                        begin
                            cmd_next.op = wrhc_pkg::OP_ADD;
                            if (cell_step[STEP_W-1])
                            begin
                                state_next = F_PUSH;
                            end
                            else if (over_range)
                            begin
                                cmd_next.idx = LIM_W'(eff_top);
                                state_next   = F_PUSH;
                            end
                            else
                            begin
                                rem_next   = cell_step[BASE_W-1:0];
                                div_next   = div_in;
                                quot_next  = '0;
                                k_next     = K_START;
                                state_next = F_DIV;
                            end
                        end
                        wrhc_pkg::OP_QUERY:
                        begin
                            cmd_next.op  = wrhc_pkg::OP_QUERY;
                            cmd_next.idx = qry_lim;
                            state_next   = F_PUSH;
                        end
                        wrhc_pkg::OP_CLEAR:
                        begin
                            cmd_next.op = wrhc_pkg::OP_CLEAR;
                            state_next  = F_PUSH;
                        end
                        default:
                        begin
                            // unused code: dropped, no result
                            state_next = F_IDLE;
                        end
                    endcase
                end
            end
            F_DIV:
            begin
                rem_next  = ge ? BASE_W'(rem_ext - shifted) : rem_reg;
                quot_next = q_full;
                if (k_reg == '0)
                begin
                    cmd_next.idx = LIM_W'(q_clamp);
                    state_next   = F_PUSH;
                end
                else
                begin
                    k_next = k_reg - K_W'(1);
                end
            end
            F_PUSH:
            begin
                if (push_ready)
                begin
                    state_next = F_IDLE;
                end
            end
            default:
            begin
                state_next = F_IDLE;
            end
        endcase
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            state_reg <= F_IDLE;
        end
        else
        begin
            state_reg <= state_next;
        end
    end

    always_ff @(posedge clk)
    begin
        cmd_reg  <= cmd_next;
        rem_reg  <= rem_next;
        div_reg  <= div_next;
        quot_reg <= quot_next;
        k_reg    <= k_next;
    end

    assign ready      = (state_reg == F_IDLE);
    assign push_valid = (state_reg == F_PUSH);
    assign push_cmd   = cmd_reg;

endmodule

### rtl/core/wrhc_queue.sv
module wrhc_queue (
    input  logic           clk,
    input  logic           rst_n,
    input  logic           push_valid,
    output logic           push_ready,
    input  wrhc_pkg::cmd_t push_cmd,
    output logic           pop_valid,
    input  logic           pop_ready,
    output wrhc_pkg::cmd_t pop_cmd
);

    localparam int DEPTH = wrhc_pkg::QUEUE_DEPTH;
    localparam int PTR_W = $clog2(DEPTH);
    localparam int CNT_W = $clog2(DEPTH + 1);

    wrhc_pkg::cmd_t    slot_reg [DEPTH];
    logic [PTR_W-1:0]  wr_ptr_reg, wr_ptr_next;
    logic [PTR_W-1:0]  rd_ptr_reg, rd_ptr_next;
    logic [CNT_W-1:0]  cnt_reg, cnt_next;
    logic              do_push;
    logic              do_pop;

    always_comb
    begin
        push_ready  = (cnt_reg != CNT_W'(DEPTH));
        pop_valid   = (cnt_reg != '0);
        pop_cmd     = slot_reg[rd_ptr_reg];
        do_push     = push_valid && push_ready;
        do_pop      = pop_valid && pop_ready;
        wr_ptr_next = do_push ? wr_ptr_reg + PTR_W'(1) : wr_ptr_reg;
        rd_ptr_next = do_pop ? rd_ptr_reg + PTR_W'(1) : rd_ptr_reg;
        cnt_next    = cnt_reg + CNT_W'(do_push) - CNT_W'(do_pop);
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            wr_ptr_reg <= '0;
            rd_ptr_reg <= '0;
            cnt_reg    <= '0;
        end
        else
        begin
            wr_ptr_reg <= wr_ptr_next;
            rd_ptr_reg <= rd_ptr_next;
            cnt_reg    <= cnt_next;
        end
    end

    always_ff @(posedge clk)
    begin
        if (do_push)
        begin
            slot_reg[wr_ptr_reg] <= push_cmd;
        end
    end

endmodule

### rtl/core/wrhc_back.sv
module wrhc_back #(
    parameter int NUM_BINS = wrhc_pkg::NUM_BINS_DEF
) (
    input  logic                            clk,
    input  logic                            rst_n,
    input  logic                            cmd_valid,
    output logic                            cmd_ready,
    input  wrhc_pkg::cmd_t                  cmd,
    output logic                            res_valid,
    input  logic                            res_ready,
    output logic [wrhc_pkg::BIN_W-1:0]      res_bin,
    output logic [wrhc_pkg::WEIGHT_W-1:0]   res_weight
);

    localparam int BIN_W    = wrhc_pkg::BIN_W;
    localparam int LIM_W    = wrhc_pkg::LIM_W;
    localparam int WEIGHT_W = wrhc_pkg::WEIGHT_W;
    localparam int BIN_CNT  = 1 << BIN_W;
    // bins past the 6-bit top are never addressed
    localparam int DEPTH    = (NUM_BINS < BIN_CNT) ? NUM_BINS : BIN_CNT;
    localparam int ADDR_W   = $clog2(DEPTH);

    typedef enum logic [3:0] {
        B_IDLE = 4'b0001,
        B_ADD  = 4'b0010,
        B_SUM  = 4'b0100,
        B_OUT  = 4'b1000
    } bstate_t;

    bstate_t               state_reg, state_next;
    wrhc_pkg::cmd_t        cur_reg, cur_next;
    logic [LIM_W-1:0]      cnt_reg, cnt_next;
    logic                  pend_reg, pend_next;
    logic [WEIGHT_W-1:0]   acc_reg, acc_next;
    logic [DEPTH-1:0]      vld_reg;
    logic                  out_valid_reg, out_valid_next;
    logic [BIN_W-1:0]      out_bin_reg, out_bin_next;
    logic [WEIGHT_W-1:0]   out_weight_reg, out_weight_next;

    logic [WEIGHT_W-1:0]   mem [DEPTH];
    logic [WEIGHT_W-1:0]   rd_data_reg;
    logic                  rd_vld_reg;
    logic [ADDR_W-1:0]     rd_addr;
    logic [ADDR_W-1:0]     wr_addr;
    logic [WEIGHT_W-1:0]   wr_data;
    logic                  wr_en;
    logic                  vld_clear;

    logic [WEIGHT_W-1:0]   rd_eff;
    logic [WEIGHT_W:0]     add_sum;
    logic [WEIGHT_W-1:0]   add_sat;
    logic [WEIGHT_W:0]     acc_sum;
    logic [WEIGHT_W-1:0]   acc_sat;
    logic                  issue;

    always_comb
    begin
        // never-written bins read as zero
        rd_eff  = rd_vld_reg ? rd_data_reg : '0;
        add_sum = {1'b0, rd_eff} + (WEIGHT_W + 1)'(cur_reg.cost);
        add_sat = add_sum[WEIGHT_W] ? wrhc_pkg::WEIGHT_MAX : add_sum[WEIGHT_W-1:0];
        acc_sum = {1'b0, acc_reg} + {1'b0, rd_eff};
        acc_sat = acc_sum[WEIGHT_W] ? wrhc_pkg::WEIGHT_MAX : acc_sum[WEIGHT_W-1:0];
        issue   = cnt_reg < cur_reg.idx;
    end

    always_comb
    begin
        state_next      = state_reg;
        cur_next        = cur_reg;
        cnt_next        = cnt_reg;
        pend_next       = pend_reg;
        acc_next        = acc_reg;
        out_valid_next  = out_valid_reg && !res_ready;
        out_bin_next    = out_bin_reg;
        out_weight_next = out_weight_reg;
        rd_addr         = '0;
        wr_addr         = cur_reg.idx[ADDR_W-1:0];
        wr_data         = add_sat;
        wr_en           = 1'b0;
        vld_clear       = 1'b0;
        cmd_ready       = (state_reg == B_IDLE);
        case (state_reg)
            B_IDLE:
            begin
                if (cmd_valid)
                begin
                    cur_next = cmd;
                    case (cmd.op)
                        wrhc_pkg::OP_ADD:
                        begin
                            rd_addr    = cmd.idx[ADDR_W-1:0];
                            state_next = B_ADD;
                        end
                        wrhc_pkg::OP_QUERY:
                        begin
                            acc_next   = '0;
                            cnt_next   = '0;
                            pend_next  = 1'b0;
                            state_next = B_SUM;
                        end
                        wrhc_pkg::OP_CLEAR:
                        begin
                            vld_clear  = 1'b1;
                            acc_next   = '0;
                            state_next = B_OUT;
                        end
                        default:
                        begin
                            state_next = B_IDLE;
                        end
                    endcase
                end
            end
            B_ADD:
            begin
                wr_en      = 1'b1;
                acc_next   = add_sat;
                state_next = B_OUT;
            end
            B_SUM:
            begin
                // read of bin cnt issued while bin cnt-1 is accumulated
                rd_addr   = cnt_reg[ADDR_W-1:0];
                pend_next = issue;
                if (issue)
                begin
                    cnt_next = cnt_reg + LIM_W'(1);
                end
                if (pend_reg)
                begin
                    acc_next = acc_sat;
                end
                if (!issue && !pend_reg)
                begin
                    state_next = B_OUT;
                end
            end
            B_OUT:
            begin
                if (!out_valid_reg || res_ready)
                begin
                    out_valid_next  = 1'b1;
                    out_bin_next    = (cur_reg.op == wrhc_pkg::OP_ADD) ?
                                      cur_reg.idx[BIN_W-1:0] : '0;
                    out_weight_next = acc_reg;
                    state_next      = B_IDLE;
                end
            end
            default:
            begin
                state_next = B_IDLE;
            end
        endcase
    end

    always_ff @(posedge clk)
    begin
        if (wr_en)
        begin
            mem[wr_addr] <= wr_data;
        end
        rd_data_reg <= mem[rd_addr];
        rd_vld_reg  <= vld_reg[rd_addr];
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            state_reg     <= B_IDLE;
            vld_reg       <= '0;
            out_valid_reg <= 1'b0;
            pend_reg      <= 1'b0;
        end
        else
        begin
            state_reg     <= state_next;
            out_valid_reg <= out_valid_next;
            pend_reg      <= pend_next;
            if (vld_clear)
            begin
                vld_reg <= '0;
            end
            else if (wr_en)
            begin
                vld_reg[wr_addr] <= 1'b1;
            end
        end
    end

    always_ff @(posedge clk)
    begin
        cur_reg        <= cur_next;
        cnt_reg        <= cnt_next;
        acc_reg        <= acc_next;
        out_bin_reg    <= out_bin_next;
        out_weight_reg <= out_weight_next;
    end

    assign res_valid  = out_valid_reg;
    assign res_bin    = out_bin_reg;
    assign res_weight = out_weight_reg;

endmodule

### rtl/core/weighted_rate_histogram_cumulative.sv
// Add path from accept to result valid: 6 divide steps, push, pop + bin read, bin write, output reg;
//   an add with negative or out-of-range step skips the divide; a query reads bins 0..lim-1 from the memory.
// The add rate is set by the 6-step quotient loop in the front, which takes a new word only once the
//   last one is pushed to the queue; queries stream one bin read per cycle from the bin memory.
// Reset (rst_n, async low): control state and bin valid bits clear at once, so every bin
//   reads zero right after reset; base_step = 1.0, top_bin = 63. No clearing sweep.
module weighted_rate_histogram_cumulative #(
    parameter int NUM_BINS = wrhc_pkg::NUM_BINS_DEF
) (
    input  logic          clk,
    input  logic          rst_n,
    wrhc_item_if.sink     item,
    wrhc_result_if.source result,
    wrhc_cfg_if.sink      cfg
);

    // Configuration registers. Written only while the block is idle (the user must keep to this; the
    // block itself does not enforce it), so the front may read them directly during its divide.
    logic [wrhc_pkg::BASE_W-1:0] base_step_reg;
    logic [wrhc_pkg::BIN_W-1:0]  top_bin_reg;

    // front -> queue -> back command path
    logic            fq_valid;
    logic            fq_ready;
    wrhc_pkg::cmd_t  fq_cmd;
    logic            qb_valid;
    logic            qb_ready;
    wrhc_pkg::cmd_t  qb_cmd;

    // config writes always taken; unknown index is a no-op
    assign cfg.ready = 1'b1;

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            base_step_reg <= wrhc_pkg::BASE_STEP_RST;
            top_bin_reg   <= wrhc_pkg::TOP_BIN_RST;
        end
        else if (cfg.valid)
        begin
            case (wrhc_pkg::reg_idx_t'(cfg.index))
                wrhc_pkg::REG_BASE_STEP:
                begin
                    base_step_reg <= cfg.data[wrhc_pkg::BASE_W-1:0];
                end
                wrhc_pkg::REG_TOP_BIN:
                begin
                    top_bin_reg <= cfg.data[wrhc_pkg::BIN_W-1:0];
                end
                default:
                begin
                    base_step_reg <= base_step_reg;
                end
            endcase
        end
    end

    // Front: takes a word, decodes the operation, maps the timestep to a bin
    // (sign check, range check, then a bit-per-cycle restoring divide for the
    // 6 quotient bits), and clamps query limits to the effective top + 1.
    wrhc_front #(
        .NUM_BINS (NUM_BINS)
    ) u_front (
        .clk        (clk),
        .rst_n      (rst_n),
        .valid      (item.valid),
        .ready      (item.ready),
        .operation  (item.operation),
        .cell_step  (item.cell_step),
        .cell_cost  (item.cell_cost),
        .query_bin  (item.query_bin),
        .base_step  (base_step_reg),
        .top_bin    (top_bin_reg),
        .push_valid (fq_valid),
        .push_cmd   (fq_cmd),
        .push_ready (fq_ready)
    );

    // Short command queue so the front can divide while the back sums.
    wrhc_queue u_queue (
        .clk        (clk),
        .rst_n      (rst_n),
        .push_valid (fq_valid),
        .push_ready (fq_ready),
        .push_cmd   (fq_cmd),
        .pop_valid  (qb_valid),
        .pop_ready  (qb_ready),
        .pop_cmd    (qb_cmd)
    );

    // Back: owns the bin memory. Add is a read-modify-write with saturation,
    // query streams bins 0..lim-1 through a saturating accumulator, clear drops
    // all valid bits. Results land in an output register.
    wrhc_back #(
        .NUM_BINS (NUM_BINS)
    ) u_back (
        .clk        (clk),
        .rst_n      (rst_n),
        .cmd_valid  (qb_valid),
        .cmd_ready  (qb_ready),
        .cmd        (qb_cmd),
        .res_valid  (result.valid),
        .res_ready  (result.ready),
        .res_bin    (result.bin_index),
        .res_weight (result.weight)
    );

endmodule
